[hw/rtl/mif_pkg.sv]
// Package for the MIDI input filter FIFO: sizes, operation codes, status bytes,
// sync event codes and the decoded-message struct.
// No dependencies.
package mif_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W      = 24;

  typedef enum logic [1:0] {
    MODE_ARRIVE = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_CONTINUE = 3'd2,
    EV_STOP     = 3'd3,
    EV_SONGPOS  = 3'd4
  } sync_evt_t;

  localparam logic [7:0] ST_SYSTEM   = 8'hF0;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_SONGPOS  = 8'hF2;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              enq;
    logic              clk_inc;
    logic              clk_clr;
    sync_evt_t         evt;
    logic [13:0]       spos;
  } msg_info_t;

endpackage

[hw/rtl/mif_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mif_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mif_msg_dec.sv]
// Message decoder: packs a MIDI message into a word, rewrites silent note-on,
// classifies queueing and sync actions. Depends on mif_pkg.
module mif_msg_dec (
  input  logic              sync_en,
  input  logic [1:0]        msg_len,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        data_one,
  input  logic [7:0]        data_two,
  output mif_pkg::msg_info_t info
);
  import mif_pkg::*;

  logic [7:0] d1;
  logic [7:0] d2;
  logic [7:0] st_out;
  logic       live;
  logic       sync_on;

  assign live    = (msg_len != 2'd0);
  assign d1      = (msg_len >= 2'd2) ? data_one : 8'h00;
  assign d2      = (msg_len == 2'd3) ? data_two : 8'h00;
  assign sync_on = live && sync_en;

  // silent note-on becomes note-off on the same channel
  assign st_out = (status_byte[7:4] == ST_NOTE_ON && d2 == 8'h00) ?
                  {ST_NOTE_OFF, status_byte[3:0]} : status_byte;

  always_comb begin
    info.word    = {d2, d1, st_out};
    info.enq     = live && (status_byte < ST_SYSTEM);
    info.clk_inc = 1'b0;
    info.clk_clr = 1'b0;
    info.evt     = EV_NONE;
    info.spos    = 14'd0;
    if (sync_on) begin
      unique case (status_byte)
        ST_CLOCK: begin
          info.clk_inc = 1'b1;
        end
        ST_SONGPOS: begin
          info.evt  = EV_SONGPOS;
          info.spos = {d2[6:0], d1[6:0]};
        end
        ST_START: begin
          info.evt     = EV_START;
          info.clk_clr = 1'b1;
        end
        ST_CONTINUE: begin
          info.evt     = EV_CONTINUE;
          info.clk_clr = 1'b1;
        end
        ST_STOP: begin
          info.evt     = EV_STOP;
          info.clk_clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/midi_in_filter_fifo.sv]
// MIDI input filter feeding a ring FIFO held in a synchronous RAM.
// Depends on mif_pkg, mif_msg_dec and mif_ram.
//
// Usage:
//   Raise start with in_mode and the message fields while busy is low; the
//   command transfers at that clock edge. Modes: arrive (queue a message),
//   pop, peek, clear. Exactly one result follows per command.
//   The result follows in the next cycle, with out_strobe high
//   for exactly one cycle; busy is high in that cycle, so no new command
//   transfers while the result is out; the RAM's read port is registered.
//   out_queue_count and out_clock_count show the state after the command.
//   The receiver cannot stall; results must be captured on the strobe.
//   The config channel (cfg_valid/cfg_ready/cfg_sync_enable) is always
//   ready; the user must write it with no command in flight (unchecked).
//   Reset (rst_n low, synchronous) empties the FIFO, zeroes the clock
//   counter and disables sync; RAM contents are not cleared and are only
//   read where a word was queued.
module midi_in_filter_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_msg_len,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_data_one,
  input  logic [7:0]  in_data_two,
  output logic        out_strobe,
  output logic [23:0] out_read_word,
  output logic        out_read_valid,
  output logic        out_dropped,
  output logic [10:0] out_queue_count,
  output logic [15:0] out_clock_count,
  output logic [2:0]  out_sync_event,
  output logic [13:0] out_song_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_sync_enable
);
  import mif_pkg::*;

  logic              sync_en_r;
  logic              pend_r;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       clocks_r, clocks_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic              drop_r, drop_nxt;
  sync_evt_t         evt_r, evt_nxt;
  logic [13:0]       spos_r, spos_nxt;
  logic              acc;
  logic              we;
  logic              re;
  logic [WORD_W-1:0] rdata;
  msg_info_t         info;
  mode_t             mode;

  assign mode      = mode_t'(in_mode);
  assign acc       = start && !pend_r;
  assign busy      = pend_r;
  assign cfg_ready = 1'b1;

  mif_msg_dec u_dec (
    .sync_en    (sync_en_r),
    .msg_len    (in_msg_len),
    .status_byte(in_status_byte),
    .data_one   (in_data_one),
    .data_two   (in_data_two),
    .info       (info)
  );

  mif_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(WORD_W)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r),
    .wdata(info.word),
    .re   (re),
    .raddr(rp_r),
    .rdata(rdata)
  );

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    clocks_nxt = clocks_r;
    rvalid_nxt = 1'b0;
    drop_nxt   = 1'b0;
    evt_nxt    = EV_NONE;
    spos_nxt   = 14'd0;
    we         = 1'b0;
    re         = 1'b0;
    if (acc) begin
      unique case (mode)
        MODE_ARRIVE: begin
          if (info.enq) begin
            if (cnt_r < CNT_W'(QUEUE_DEPTH)) begin
              we      = 1'b1;
              wp_nxt  = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (info.clk_inc) begin
            clocks_nxt = clocks_r + 16'd1;
          end else if (info.clk_clr) begin
            clocks_nxt = 16'd0;
          end
          evt_nxt  = info.evt;
          spos_nxt = info.spos;
        end
        MODE_POP, MODE_PEEK: begin
          if (cnt_r != '0) begin
            re         = 1'b1;
            rvalid_nxt = 1'b1;
            if (mode == MODE_POP) begin
              rp_nxt  = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        MODE_CLEAR: begin
          wp_nxt  = '0;
          rp_nxt  = '0;
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_en_r <= 1'b0;
      pend_r    <= 1'b0;
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      clocks_r  <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sync_en_r <= cfg_sync_enable;
      end
      pend_r   <= acc;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      cnt_r    <= cnt_nxt;
      clocks_r <= clocks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rvalid_r <= rvalid_nxt;
    drop_r   <= drop_nxt;
    evt_r    <= evt_nxt;
    spos_r   <= spos_nxt;
  end

  assign out_strobe        = pend_r;
  assign out_read_word     = rvalid_r ? rdata : '0;
  assign out_read_valid    = rvalid_r;
  assign out_dropped       = drop_r;
  assign out_queue_count   = 11'(cnt_r);
  assign out_clock_count   = clocks_r;
  assign out_sync_event    = evt_r;
  assign out_song_position = spos_r;

  a_strobe_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc))
    else $error("result strobe without a preceding command transfer");

  a_read_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_read_valid && out_dropped))
    else $error("read and drop flagged together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("element count beyond queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNT_W'(QUEUE_DEPTH)) |-> (wp_r == rp_r))
    else $error("pointers disagree with element count");

endmodule
